>>> hdl/mie_pkg.sv
`default_nettype none

package mie_pkg;

  // Default operand width and the width and reset value of the limit register.
  localparam int unsigned WIDTH_DEF   = 32;
  localparam int unsigned LIMIT_W     = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new operand pair and seed the recurrence
    logic div_init;  // start a division of r_old by r_cur
    logic div_bit;   // produce one quotient bit
    logic step;      // advance the recurrence and start the next division
    logic adj;       // bring the coefficient into the range of the modulus
    logic fin;       // form the answer into the output register
  } mie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_in;   // modulus or value was zero
    logic div_last;  // the current quotient bit is the last one
    logic rem_zero;  // the finished division left no remainder
  } mie_sts_t;

endpackage

`default_nettype wire

>>> hdl/mie_ctrl.sv
`default_nettype none

module mie_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire mie_pkg::mie_sts_t sts,
  output mie_pkg::mie_cmd_t     cmd
);
  import mie_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_STEP,
    ST_ADJ,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new answer when it is empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.zero_in) begin
          state_nxt = ST_ADJ;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_bit = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.rem_zero) begin
          state_nxt = ST_ADJ;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_ADJ: begin
        cmd.adj   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hdl/mie_dp.sv
`default_nettype none

module mie_dp #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic [WIDTH-1:0]            in_modulus,
  input  wire logic [WIDTH-1:0]            in_value,
  input  wire logic [mie_pkg::LIMIT_W-1:0] limit,
  input  wire mie_pkg::mie_cmd_t           cmd,
  output mie_pkg::mie_sts_t                sts,
  output logic                             out_status,
  output logic [WIDTH-1:0]                 out_result
);
  import mie_pkg::*;

  // Coefficients are two's complement with two spare bits over the modulus.
  localparam int unsigned TW = WIDTH + 2;
  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0]  k_r, c_r;
  logic              zero_r;
  logic [WIDTH-1:0]  r_old_r, r_old_nxt, r_cur_r, r_cur_nxt;
  logic [TW-1:0]     t_old_r, t_old_nxt, t_cur_r, t_cur_nxt;
  logic [WIDTH-1:0]  sh_r, sh_nxt;
  logic [WIDTH-1:0]  rem_r, rem_nxt;
  logic [TW-1:0]     acc_r, acc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_status_r;
  logic [WIDTH-1:0]  out_result_r;

  logic [WIDTH:0]    rem_sh, rem_diff, limit_m, sum1, v, v_fix, k_ext;
  logic              ge;
  logic              fin_status;
  logic [WIDTH-1:0]  fin_result;

  // Limit as seen at the operand width: masked when the operands are narrower.
  generate
    if (WIDTH >= LIMIT_W) begin : g_lim_wide
      assign limit_m = {{(WIDTH + 1 - LIMIT_W){1'b0}}, limit};
    end else begin : g_lim_narrow
      assign limit_m = {1'b0, limit[WIDTH-1:0]};
    end
  endgenerate

  // One restoring division bit; the quotient times t_cur is built alongside.
  assign rem_sh   = {rem_r, sh_r[WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, r_cur_r};
  assign ge       = (rem_sh >= {1'b0, r_cur_r});

  always_comb begin
    r_old_nxt = r_old_r;
    r_cur_nxt = r_cur_r;
    t_old_nxt = t_old_r;
    t_cur_nxt = t_cur_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    if (cmd.load) begin
      r_old_nxt = in_modulus;
      r_cur_nxt = in_value;
      t_old_nxt = '0;
      t_cur_nxt = TW'(1);
    end
    if (cmd.div_init) begin
      sh_nxt  = r_old_r;
      rem_nxt = '0;
      acc_nxt = '0;
      cnt_nxt = CW'(WIDTH - 1);
    end
    if (cmd.div_bit) begin
      sh_nxt  = {sh_r[WIDTH-2:0], 1'b0};
      rem_nxt = ge ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      acc_nxt = {acc_r[TW-2:0], 1'b0} + (ge ? t_cur_r : '0);
      cnt_nxt = cnt_r - CW'(1);
    end
    // Shift the recurrence on and divide the old r_cur by the remainder next.
    if (cmd.step) begin
      r_old_nxt = r_cur_r;
      r_cur_nxt = rem_r;
      t_old_nxt = t_cur_r;
      t_cur_nxt = t_old_r - acc_r;
      sh_nxt    = r_cur_r;
      rem_nxt   = '0;
      acc_nxt   = '0;
      cnt_nxt   = CW'(WIDTH - 1);
    end
    // A negative coefficient is lifted by one modulus into the accumulator.
    if (cmd.adj) begin
      acc_nxt = t_cur_r[TW-1] ? (t_cur_r + {2'b00, k_r}) : t_cur_r;
    end
  end

  // Answer selection for the special cases and the general case.
  assign k_ext = {1'b0, k_r};
  assign sum1  = k_ext + {{WIDTH{1'b0}}, 1'b1};
  assign v     = acc_r[WIDTH:0];
  assign v_fix = (v >= k_ext) ? (v - k_ext) : v;

  always_comb begin
    fin_status = 1'b0;
    fin_result = '0;
    if (zero_r || (r_cur_r != WIDTH'(1))) begin
      fin_status = 1'b1;
    end else if (c_r == WIDTH'(1)) begin
      if (sum1 > limit_m) begin
        fin_status = 1'b1;
      end else begin
        fin_result = sum1[WIDTH-1:0];
      end
    end else if (k_r == WIDTH'(1)) begin
      fin_result = WIDTH'(1);
    end else begin
      fin_result = v_fix[WIDTH-1:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r    <= in_modulus;
      c_r    <= in_value;
      zero_r <= (in_modulus == '0) || (in_value == '0);
    end
    r_old_r <= r_old_nxt;
    r_cur_r <= r_cur_nxt;
    t_old_r <= t_old_nxt;
    t_cur_r <= t_cur_nxt;
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    if (cmd.fin) begin
      out_status_r <= fin_status;
      out_result_r <= fin_result;
    end
  end

  assign sts.zero_in  = zero_r;
  assign sts.div_last = (cnt_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign out_status   = out_status_r;
  assign out_result   = out_result_r;

endmodule

`default_nettype wire

>>> hdl/modular_inverse_ext_euclid_top.sv
`default_nettype none

// Modular inverse by the extended Euclidean algorithm. Each transfer on the
// input channel carries a modulus and a value; one transfer on the result
// channel returns the inverse of the value modulo the modulus, or status 1
// (impossible, result 0) when the gcd is not one or either operand is zero.
// A value of one answers modulus plus one, impossible when that exceeds the
// result limit register; a modulus of one answers one unless the value is one.
// Items are handled one at a time. Each Euclid step runs on a shared restoring
// divider that yields one quotient bit a cycle, and an item takes as many
// steps as its remainder sequence is long (up to about 46 at 32 bits). A new
// item is accepted while the previous answer still waits in the output
// register. The limit is written through the cfg channel, which is always
// ready and is to be used only while the block is idle.
module modular_inverse_ext_euclid_top #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [WIDTH-1:0]            in_modulus,
  input  wire logic [WIDTH-1:0]            in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic [WIDTH-1:0]                 out_result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mie_pkg::LIMIT_W-1:0] cfg_data
);
  import mie_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  mie_cmd_t           cmd;
  mie_sts_t           sts;

  // Result limit register, written by a cfg transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .in_modulus (in_modulus),
    .in_value   (in_value),
    .limit      (limit_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_status),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
